[src/float_to_fixed_decimal_ascii_defines.svh]
// Assertion macros shared by the checker of the decimal text formatter.
// No dependencies; included by the checker file only.
`ifndef FLOAT_TO_FIXED_DECIMAL_ASCII_DEFINES_SVH
`define FLOAT_TO_FIXED_DECIMAL_ASCII_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define FDEC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block's own clock and reset names
`define FDEC_ASSERT(lbl, prop, msg) \
  `FDEC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[src/fdec_pkg.sv]
// Shared types, constants and lookup functions of the decimal text formatter.
// No dependencies; imported by every module of the block.
package fdec_pkg;

  localparam int unsigned MAX_FRACTION_DIGITS = 6;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W = 4 * NUM_DIGITS;
  localparam int unsigned MANT_W = 24;
  localparam int unsigned MULT_W = 20;
  localparam int unsigned PROD_W = MANT_W + MULT_W;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [2:0]  frac_digits;
  } fdec_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } fdec_out_t;

  typedef enum logic [1:0] {SPEC_NONE, SPEC_NAN, SPEC_INF} spec_e;
  typedef enum logic [2:0] {OP_IDLE, OP_LOAD, OP_MUL, OP_RND, OP_SCALE, OP_CONV,
                            OP_EMIT} op_e;
  typedef enum logic [1:0] {CH_DIGIT, CH_POINT, CH_MINUS, CH_SPEC} chr_e;

  // controller to datapath
  typedef struct packed {
    op_e        op;
    chr_e       chr;
    logic [3:0] idx;
    logic       last;
  } fdec_cmd_t;

  // datapath to controller
  typedef struct packed {
    spec_e      spec;
    logic       neg;
    logic [2:0] digits;
    logic [3:0] start_pos;
  } fdec_stat_t;

  function automatic logic [2:0] clamp_digits(input logic [2:0] d);
    return (d > 3'(MAX_FRACTION_DIGITS)) ? 3'(MAX_FRACTION_DIGITS) : d;
  endfunction

  // 10^d
  function automatic logic [MULT_W-1:0] pow10(input logic [2:0] d);
    logic [MULT_W-1:0] m;
    unique case (d)
      3'd0:    m = 20'd1;
      3'd1:    m = 20'd10;
      3'd2:    m = 20'd100;
      3'd3:    m = 20'd1000;
      3'd4:    m = 20'd10000;
      3'd5:    m = 20'd100000;
      default: m = 20'd1000000;
    endcase
    return m;
  endfunction

  // position of the leading one of 10^d
  function automatic logic [4:0] pow10_msb(input logic [2:0] d);
    logic [4:0] p;
    unique case (d)
      3'd0:    p = 5'd0;
      3'd1:    p = 5'd3;
      3'd2:    p = 5'd6;
      3'd3:    p = 5'd9;
      3'd4:    p = 5'd13;
      3'd5:    p = 5'd16;
      default: p = 5'd19;
    endcase
    return p;
  endfunction

  // single-precision 2^32 / 10^d, sign dropped
  function automatic logic [30:0] limit_bits(input logic [2:0] d);
    logic [30:0] l;
    unique case (d)
      3'd0:    l = 31'h4F800000;
      3'd1:    l = 31'h4DCCCCCD;
      3'd2:    l = 31'h4C23D70A;
      3'd3:    l = 31'h4A83126F;
      3'd4:    l = 31'h48D1B717;
      3'd5:    l = 31'h4727C5AC;
      default: l = 31'h458637BD;
    endcase
    return l;
  endfunction

  // "nan" / "inf" text
  function automatic logic [7:0] spec_char(input spec_e s, input logic [1:0] i);
    logic [7:0] c;
    if (s == SPEC_NAN) begin
      c = (i == 2'd1) ? 8'h61 : 8'h6E;
    end else begin
      unique case (i)
        2'd0:    c = 8'h69;
        2'd1:    c = 8'h6E;
        default: c = 8'h66;
      endcase
    end
    return c;
  endfunction

  // one shift-and-add-3 step of binary to BCD
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
    logic [BCD_W-1:0] a;
    a = b;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (a[4*i +: 4] >= 4'd5) a[4*i +: 4] = a[4*i +: 4] + 4'd3;
    end
    return {a[BCD_W-2:0], bit_in};
  endfunction

endpackage

[src/float_to_fixed_decimal_ascii.sv]
// Decimal text formatter for single-precision values: top level.
// Depends on fdec_pkg, fdec_ctrl and fdec_dp.
//
// One value is taken when start is high and busy is low; the text then
// leaves one character per strobe_o cycle, last set on the final one, and
// the receiver has no way to stall it. For a finite value busy stays
// high through multiply, round, half-add and truncate, binary-to-BCD
// conversion at two bits a cycle, digit placement, then the characters, one
// per cycle. For "nan" and "inf" it covers the multiply step, then the three
// characters. Busy falls as the last character is issued, so a new value may
// be taken while that character is still on the port.
module float_to_fixed_decimal_ascii import fdec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  fdec_in_t  in_i,
  output logic      strobe_o,
  output fdec_out_t out_o
);

  fdec_cmd_t  cmd;
  fdec_stat_t stat;

  fdec_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  fdec_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .strobe_o (strobe_o),
    .out_o    (out_o)
  );

endmodule

[src/fdec_ctrl.sv]
// Sequencing state machine of the decimal text formatter.
// Depends on fdec_pkg; drives fdec_dp through command and status structs.
module fdec_ctrl import fdec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  fdec_stat_t stat_i,
  output fdec_cmd_t  cmd_o,
  output logic       busy_o
);

  typedef enum logic [3:0] {S_IDLE, S_MUL, S_RND, S_SCALE, S_CONV, S_PLACE, S_SIGN,
                            S_DIGIT, S_POINT, S_SPEC} state_e;

  state_e     state_q;
  logic [3:0] ptr_q;
  logic [3:0] cnt_q;

  assign busy_o = (state_q != S_IDLE);

  // command decode
  always_comb begin
    cmd_o = '{op: OP_IDLE, chr: CH_DIGIT, idx: ptr_q, last: 1'b0};
    unique case (state_q)
      S_IDLE:  cmd_o.op = start_i ? OP_LOAD : OP_IDLE;
      S_MUL:   cmd_o.op = OP_MUL;
      S_RND:   cmd_o.op = OP_RND;
      S_SCALE: cmd_o.op = OP_SCALE;
      S_CONV:  cmd_o.op = OP_CONV;
      S_PLACE: cmd_o.op = OP_IDLE;
      S_SIGN: begin
        cmd_o.op  = OP_EMIT;
        cmd_o.chr = CH_MINUS;
      end
      S_DIGIT: begin
        cmd_o.op   = OP_EMIT;
        cmd_o.last = (ptr_q == 4'd0);
      end
      S_POINT: begin
        cmd_o.op  = OP_EMIT;
        cmd_o.chr = CH_POINT;
      end
      S_SPEC: begin
        cmd_o.op   = OP_EMIT;
        cmd_o.chr  = CH_SPEC;
        cmd_o.last = (ptr_q == 4'd2);
      end
      default: cmd_o.op = OP_IDLE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE:  if (start_i) state_q <= S_MUL;
        S_MUL: begin
          ptr_q   <= '0;
          state_q <= (stat_i.spec != SPEC_NONE) ? S_SPEC : S_RND;
        end
        S_RND:   state_q <= S_SCALE;
        S_SCALE: begin
          cnt_q   <= '0;
          state_q <= S_CONV;
        end
        S_CONV: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) state_q <= S_PLACE;
        end
        S_PLACE: begin
          ptr_q   <= stat_i.start_pos;
          state_q <= stat_i.neg ? S_SIGN : S_DIGIT;
        end
        S_SIGN:  state_q <= S_DIGIT;
        S_DIGIT: begin
          if (ptr_q == 4'd0) begin
            state_q <= S_IDLE;
          end else begin
            ptr_q <= ptr_q - 4'd1;
            if (ptr_q == {1'b0, stat_i.digits} && stat_i.digits != 3'd0) state_q <= S_POINT;
          end
        end
        S_POINT: state_q <= S_DIGIT;
        S_SPEC: begin
          ptr_q <= ptr_q + 4'd1;
          if (ptr_q == 4'd2) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[src/fdec_dp.sv]
// Datapath of the decimal text formatter: scaling, float rounding, BCD
// conversion and character register. Depends on fdec_pkg.
module fdec_dp import fdec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fdec_in_t   in_i,
  input  fdec_cmd_t  cmd_i,
  output fdec_stat_t stat_o,
  output logic       strobe_o,
  output fdec_out_t  out_o
);

  logic [MANT_W-1:0] mant_q;
  logic [7:0]        exp_q;
  logic              tiny_q;
  logic              neg_q;
  logic [2:0]        dig_q;
  spec_e             spec_q;
  logic [PROD_W-1:0] prod_q;
  logic [MANT_W:0]   qr_q;
  logic signed [9:0] e2_q;
  logic [31:0]       shift_q;
  logic [BCD_W-1:0]  bcd_q;
  fdec_out_t         out_q;
  logic              strobe_q;

  // input classification
  logic [2:0]  in_dig;
  logic [30:0] in_mag;
  spec_e       in_spec;
  always_comb begin
    in_dig = clamp_digits(in_i.frac_digits);
    in_mag = in_i.value_bits[30:0];
    if (in_mag[30:23] == 8'hFF)             in_spec = SPEC_NAN;
    else if (in_mag > limit_bits(in_dig))   in_spec = SPEC_INF;
    else                                    in_spec = SPEC_NONE;
  end

  // round the product to 24 significant bits
  logic [4:0]        msb;
  logic [5:0]        hi_idx;
  logic [4:0]        rsh;
  logic [PROD_W-1:0] shifted;
  logic [PROD_W-1:0] low_mask;
  logic              guard;
  logic              sticky;
  logic [MANT_W:0]   qr_d;
  logic signed [9:0] e2_d;
  always_comb begin
    msb      = pow10_msb(dig_q);
    hi_idx   = 6'd24 + {1'b0, msb};
    rsh      = msb + {4'd0, prod_q[hi_idx]};
    shifted  = prod_q >> rsh;
    low_mask = (44'd1 << rsh) - 44'd1;
    guard    = |(prod_q & (low_mask ^ (low_mask >> 1)));
    sticky   = |(prod_q & (low_mask >> 1));
    qr_d     = {1'b0, shifted[MANT_W-1:0]}
             + (MANT_W+1)'(guard & (sticky | shifted[0]));
    e2_d     = $signed({2'b00, exp_q}) - 10'sd150 + $signed({5'b00000, rsh});
  end

  // add one half in single precision, then truncate
  logic [34:0] v;
  logic [9:0]  neg_e2;
  logic [4:0]  n;
  logic [25:0] s;
  logic [25:0] keep;
  logic [26:0] sr;
  logic [31:0] scaled;
  always_comb begin
    v      = 35'(qr_q) << e2_q[3:0];
    neg_e2 = 10'(-e2_q);
    n      = neg_e2[4:0];
    s      = 26'(qr_q) + (26'd1 << (n - 5'd1));
    keep   = '0;
    sr     = 27'(s);
    if (s[25]) begin
      keep = s >> 2;
      sr   = 27'(keep + 26'(s[1] & (s[0] | keep[0]))) << 2;
    end else if (s[24]) begin
      keep = s >> 1;
      sr   = 27'(keep + 26'(s[0] & keep[0])) << 1;
    end
    priority if (tiny_q || e2_q < -10'sd25) begin
      scaled = '0;
    end else if (e2_q > 10'sd10) begin
      scaled = '1;
    end else if (e2_q >= 10'sd0) begin
      if (v < 35'd16777216 && v[0]) v = v + 35'd1;
      scaled = (|v[34:32]) ? '1 : v[31:0];
    end else begin
      scaled = 32'(sr >> n);
    end
  end

  // leading digit search over the BCD result
  logic [3:0] hi_dig;
  always_comb begin
    hi_dig = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) hi_dig = 4'(i);
    end
  end

  assign stat_o = '{spec: spec_q, neg: neg_q, digits: dig_q,
                    start_pos: (hi_dig > {1'b0, dig_q}) ? hi_dig : {1'b0, dig_q}};

  // character select
  logic [3:0] cur_dig;
  logic [7:0] chr;
  always_comb begin
    cur_dig = bcd_q[{cmd_i.idx, 2'b00} +: 4];
    unique case (cmd_i.chr)
      CH_DIGIT: chr = CHAR_ZERO + {4'd0, cur_dig};
      CH_POINT: chr = CHAR_POINT;
      CH_MINUS: chr = CHAR_MINUS;
      default:  chr = spec_char(spec_q, cmd_i.idx[1:0]);
    endcase
  end

  // strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) strobe_q <= 1'b0;
    else         strobe_q <= (cmd_i.op == OP_EMIT);
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        dig_q  <= in_dig;
        spec_q <= in_spec;
        neg_q  <= in_i.value_bits[31];
        exp_q  <= in_mag[30:23];
        tiny_q <= (in_mag[30:23] == 8'h00);
        mant_q <= {1'b1, in_mag[22:0]};
      end
      OP_MUL: prod_q <= mant_q * pow10(dig_q);
      OP_RND: begin
        qr_q <= qr_d;
        e2_q <= e2_d;
      end
      OP_SCALE: begin
        shift_q <= scaled;
        bcd_q   <= '0;
        neg_q   <= neg_q & (scaled != 32'd0);
      end
      OP_CONV: begin
        bcd_q   <= dabble(dabble(bcd_q, shift_q[31]), shift_q[30]);
        shift_q <= {shift_q[29:0], 2'b00};
      end
      OP_EMIT: out_q <= '{out_char: chr, last: cmd_i.last};
      default: ;
    endcase
  end

  assign strobe_o = strobe_q;
  assign out_o    = out_q;

endmodule

[src/fdec_checker.sv]
// Port-level checks of the decimal text formatter, bound to the top level.
// Depends on fdec_pkg and the assertion macro header.
`include "float_to_fixed_decimal_ascii_defines.svh"

module fdec_checker import fdec_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      strobe_o,
  input fdec_out_t out_o
);

  // a taken value makes the block busy
  `FDEC_ASSERT(a_busy_after_start, start && !busy |=> busy, "not busy after start")
  // no beat directly after a value is taken
  `FDEC_ASSERT(a_quiet_after_start, start && !busy |=> !strobe_o, "beat after start")
  // the final beat is never followed at once by another
  `FDEC_ASSERT(a_gap_after_last, strobe_o && out_o.last |=> !strobe_o, "beat after last")
  // more text to come means still busy
  `FDEC_ASSERT(a_busy_mid_text, strobe_o && !out_o.last |-> busy, "idle mid text")

endmodule

bind float_to_fixed_decimal_ascii fdec_checker u_fdec_checker (.*);
